@@ src/twpfs_pkg.sv @@
`default_nettype none

package twpfs_pkg;

  // Configuration port
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 12;
  localparam int unsigned EFF_W      = 10;
  localparam int unsigned LVL_W      = 12;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_EFF0   = 3'd0,
    CFG_EFF1   = 3'd1,
    CFG_EFF2   = 3'd2,
    CFG_DEAD   = 3'd3,
    CFG_FLOOR0 = 3'd4,
    CFG_FLOOR1 = 3'd5,
    CFG_FLOOR2 = 3'd6,
    CFG_CAP    = 3'd7
  } cfg_idx_e;

  // Register file as seen by the datapath
  typedef struct packed {
    logic [2:0][EFF_W-1:0] eff;
    logic [LVL_W-1:0]      dead;
    logic [2:0][LVL_W-1:0] floors;
    logic [LVL_W-1:0]      cap;
  } cfg_t;

  localparam logic [EFF_W-1:0] EFF_DEFAULT = 10'd100;
  localparam int unsigned      EFF_SCALE   = 25600;   // 100 * 2^8

  // Gain, unsigned Q8.16
  localparam int unsigned K_W   = 24;
  localparam logic [K_W-1:0] K_ONE = 24'h01_0000;
  localparam logic [K_W-1:0] K_MAX = 24'hFF_FFFF;

  // Qualification ratio: mag * 100 >= amax * 35
  localparam int unsigned QUAL_NUM = 100;
  localparam int unsigned QUAL_DEN = 35;

  // Queue between front and back
  localparam int unsigned FIFO_DEPTH = 4;
  localparam int unsigned FIFO_AW    = 2;

endpackage

`default_nettype wire

@@ src/twpfs_if.sv @@
`default_nettype none

interface twpfs_raw_if #(parameter int unsigned DRIVE_BITS = 13);
  logic                  valid;
  logic                  ready;
  logic [DRIVE_BITS-1:0] wheel0_raw;
  logic [DRIVE_BITS-1:0] wheel1_raw;
  logic [DRIVE_BITS-1:0] wheel2_raw;

  modport source (output valid, wheel0_raw, wheel1_raw, wheel2_raw, input ready);
  modport sink   (input valid, wheel0_raw, wheel1_raw, wheel2_raw, output ready);
endinterface

interface twpfs_drive_if #(parameter int unsigned DRIVE_BITS = 13);
  logic                  valid;
  logic                  ready;
  logic [DRIVE_BITS-1:0] wheel0_drive;
  logic [DRIVE_BITS-1:0] wheel1_drive;
  logic [DRIVE_BITS-1:0] wheel2_drive;

  modport source (output valid, wheel0_drive, wheel1_drive, wheel2_drive, input ready);
  modport sink   (input valid, wheel0_drive, wheel1_drive, wheel2_drive, output ready);
endinterface

interface twpfs_cfg_if import twpfs_pkg::*;;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

@@ src/twpfs_div.sv @@
`default_nettype none

// Pipelined restoring divider, one quotient bit per stage.
// Starts from a partial remainder below the divisor and shifts in STEPS
// numerator bits; the shift register ends up holding the quotient.
module twpfs_div #(
  parameter int unsigned DEN_W  = 10,
  parameter int unsigned STEPS  = 28,
  parameter int unsigned SIDE_W = 1
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              en_i,
  input  logic              valid_i,
  input  logic [DEN_W-1:0]  rem_i,
  input  logic [DEN_W-1:0]  den_i,
  input  logic [STEPS-1:0]  num_i,
  input  logic [SIDE_W-1:0] side_i,
  output logic              valid_o,
  output logic [STEPS-1:0]  quo_o,
  output logic              rem_nz_o,
  output logic [SIDE_W-1:0] side_o
);

  logic [STEPS:0]      vld_q;
  logic [DEN_W-1:0]    rem_q  [STEPS+1];
  logic [DEN_W-1:0]    den_q  [STEPS+1];
  logic [STEPS-1:0]    bits_q [STEPS+1];
  logic [SIDE_W-1:0]   side_q [STEPS+1];

  // Load stage
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q[0] <= 1'b0;
    end else if (en_i) begin
      vld_q[0] <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_q[0]  <= rem_i;
      den_q[0]  <= den_i;
      bits_q[0] <= num_i;
      side_q[0] <= side_i;
    end
  end

  // One trial subtraction per stage
  for (genvar j = 0; j < STEPS; j++) begin : g_stage
    logic [DEN_W:0]   cat;
    logic             ge;
    logic [DEN_W:0]   diff;
    logic [DEN_W-1:0] rem_d;

    always_comb begin
      cat   = {rem_q[j], bits_q[j][STEPS-1]};
      ge    = cat >= {1'b0, den_q[j]};
      diff  = cat - {1'b0, den_q[j]};
      rem_d = ge ? diff[DEN_W-1:0] : cat[DEN_W-1:0];
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[j+1] <= 1'b0;
      end else if (en_i) begin
        vld_q[j+1] <= vld_q[j];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[j+1]  <= rem_d;
        den_q[j+1]  <= den_q[j];
        bits_q[j+1] <= {bits_q[j][STEPS-2:0], ge};
        side_q[j+1] <= side_q[j];
      end
    end
  end

  assign valid_o  = vld_q[STEPS];
  assign quo_o    = bits_q[STEPS];
  assign rem_nz_o = |rem_q[STEPS];
  assign side_o   = side_q[STEPS];

endmodule

`default_nettype wire

@@ src/twpfs_front.sv @@
`default_nettype none

// Front: takes magnitudes, divides by efficiency, applies the dead band
// and pushes one classified entry per item into the queue.
module twpfs_front import twpfs_pkg::*; #(
  parameter int unsigned DRIVE_BITS = 13,
  localparam int unsigned WW    = DRIVE_BITS + 7,
  localparam int unsigned ENT_W = 6 + 3 * WW
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  cfg_t                       cfg_i,
  input  logic                       in_valid_i,
  output logic                       in_ready_o,
  input  logic [2:0][DRIVE_BITS-1:0] raw_i,
  input  logic                       fifo_full_i,
  output logic                       push_o,
  output logic [ENT_W-1:0]           entry_o
);

  localparam int unsigned NUM_W = DRIVE_BITS + 15;
  localparam int unsigned CW    = (WW > LVL_W + 8) ? WW : LVL_W + 8;

  logic                  en;
  logic                  vld_p_q;
  logic [2:0]            neg_p_q;
  logic [NUM_W-1:0]      prod_p_q [3];
  logic [EFF_W-1:0]      eff_p_q  [3];
  logic [2:0]            neg_in;
  logic [DRIVE_BITS-1:0] mag_in   [3];
  logic [NUM_W-1:0]      prod_d   [3];
  logic [EFF_W-1:0]      eff_d    [3];

  logic [2:0]            div_vld;
  logic [2:0]            div_neg;
  logic [NUM_W-1:0]      quo      [3];
  logic [2:0]            act;
  logic [2:0][WW-1:0]    mag;
  logic                  out_vld;

  assign out_vld    = &div_vld;
  assign en         = !fifo_full_i || !out_vld;
  assign in_ready_o = en;
  assign push_o     = out_vld && !fifo_full_i;

  // Magnitude, scale by 25600, effective efficiency
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      neg_in[i] = raw_i[i][DRIVE_BITS-1];
      mag_in[i] = neg_in[i] ? (~raw_i[i] + 1'b1) : raw_i[i];
      prod_d[i] = NUM_W'(mag_in[i]) * NUM_W'(EFF_SCALE);
      eff_d[i]  = (cfg_i.eff[i] == '0) ? EFF_DEFAULT : cfg_i.eff[i];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_p_q <= 1'b0;
    end else if (en) begin
      vld_p_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      neg_p_q <= neg_in;
      for (int i = 0; i < 3; i++) begin
        prod_p_q[i] <= prod_d[i];
        eff_p_q[i]  <= eff_d[i];
      end
    end
  end

  for (genvar i = 0; i < 3; i++) begin : g_div
    twpfs_div #(
      .DEN_W (EFF_W),
      .STEPS (NUM_W),
      .SIDE_W(1)
    ) u_div (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (en),
      .valid_i (vld_p_q),
      .rem_i   ('0),
      .den_i   (eff_p_q[i]),
      .num_i   (prod_p_q[i]),
      .side_i  (neg_p_q[i]),
      .valid_o (div_vld[i]),
      .quo_o   (quo[i]),
      .rem_nz_o(),
      .side_o  (div_neg[i])
    );
  end

  // Saturate and apply the dead band
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      logic [WW-1:0] w;
      w      = (|quo[i][NUM_W-1:WW]) ? '1 : quo[i][WW-1:0];
      act[i] = CW'(w) > CW'({cfg_i.dead, 8'h00});
      mag[i] = act[i] ? w : '0;
    end
  end

  assign entry_o = {act, div_neg, mag};

endmodule

`default_nettype wire

@@ src/twpfs_fifo.sv @@
`default_nettype none

// Small queue between front and back.
module twpfs_fifo import twpfs_pkg::*; #(
  parameter int unsigned W = 66
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         push_i,
  input  logic [W-1:0] data_i,
  input  logic         pop_i,
  output logic [W-1:0] data_o,
  output logic         full_o,
  output logic         empty_o
);

  logic [W-1:0]         mem_q [FIFO_DEPTH];
  logic [FIFO_AW-1:0]   wr_q, rd_q;
  logic [FIFO_AW:0]     cnt_q;

  assign full_o  = cnt_q == (FIFO_AW+1)'(FIFO_DEPTH);
  assign empty_o = cnt_q == '0;
  assign data_o  = mem_q[rd_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) wr_q <= wr_q + 1'b1;
      if (pop_i)  rd_q <= rd_q + 1'b1;
      cnt_q <= cnt_q + (FIFO_AW+1)'(push_i) - (FIFO_AW+1)'(pop_i);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= data_i;
    end
  end

endmodule

`default_nettype wire

@@ src/twpfs_back.sv @@
`default_nettype none

// Back: shared gain from floors and thermal cap, scaling, rounding.
module twpfs_back import twpfs_pkg::*; #(
  parameter int unsigned DRIVE_BITS = 13,
  localparam int unsigned WW    = DRIVE_BITS + 7,
  localparam int unsigned ENT_W = 6 + 3 * WW
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  cfg_t                       cfg_i,
  input  logic                       fifo_empty_i,
  input  logic [ENT_W-1:0]           entry_i,
  output logic                       pop_o,
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output logic [2:0][DRIVE_BITS-1:0] drive_o
);

  localparam int unsigned PW     = WW + 7;
  localparam int unsigned PROD_W = WW + K_W;
  localparam int unsigned SIDE_W = 1 + 6 + 3 * WW;

  logic en;
  logic out_vld_q;

  assign en    = !out_vld_q || out_ready_i;
  assign pop_o = !fifo_empty_i && en;

  // Stage 1: entry from the queue
  logic               b1_vld_q;
  logic [2:0]         b1_act_q, b1_neg_q;
  logic [2:0][WW-1:0] b1_mag_q;

  // Stage 2: largest magnitude
  logic               b2_vld_q;
  logic [2:0]         b2_act_q, b2_neg_q;
  logic [2:0][WW-1:0] b2_mag_q;
  logic [WW-1:0]      b2_amax_q;
  logic [WW-1:0]      amax_d;

  // Stage 3: ratio products
  logic               b3_vld_q;
  logic [2:0]         b3_act_q, b3_neg_q;
  logic [2:0][WW-1:0] b3_mag_q;
  logic [WW-1:0]      b3_amax_q;
  logic [PW-1:0]      b3_p100_q [3];
  logic [PW-1:0]      b3_p35_q;

  always_comb begin
    amax_d = b1_mag_q[0];
    if (b1_mag_q[1] > amax_d) amax_d = b1_mag_q[1];
    if (b1_mag_q[2] > amax_d) amax_d = b1_mag_q[2];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b1_vld_q <= 1'b0;
      b2_vld_q <= 1'b0;
      b3_vld_q <= 1'b0;
    end else if (en) begin
      b1_vld_q <= pop_o;
      b2_vld_q <= b1_vld_q;
      b3_vld_q <= b2_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      {b1_act_q, b1_neg_q, b1_mag_q} <= entry_i;
      b2_act_q  <= b1_act_q;
      b2_neg_q  <= b1_neg_q;
      b2_mag_q  <= b1_mag_q;
      b2_amax_q <= amax_d;
      b3_act_q  <= b2_act_q;
      b3_neg_q  <= b2_neg_q;
      b3_mag_q  <= b2_mag_q;
      b3_amax_q <= b2_amax_q;
      b3_p35_q  <= PW'(b2_amax_q) * PW'(QUAL_DEN);
      for (int i = 0; i < 3; i++) begin
        b3_p100_q[i] <= PW'(b2_mag_q[i]) * PW'(QUAL_NUM);
      end
    end
  end

  // Divider setup: floor lift per wheel, cap quotient
  logic [2:0]    qual, big;
  logic          nocap;
  logic [WW-1:0] need_rem [3];
  logic [WW-1:0] cap_rem;
  logic [WW-1:0] cap_w;

  always_comb begin
    cap_w = WW'(cfg_i.cap);
    nocap = (cfg_i.cap == '0) || (b3_amax_q == '0) || (cap_w >= b3_amax_q);
    cap_rem = nocap ? '0 : cap_w;
    for (int i = 0; i < 3; i++) begin
      qual[i]     = b3_act_q[i] && (b3_p100_q[i] >= b3_p35_q);
      big[i]      = WW'(cfg_i.floors[i]) >= b3_mag_q[i];
      need_rem[i] = big[i] ? '0 : WW'(cfg_i.floors[i]);
    end
  end

  logic [2:0]         nd_vld;
  logic [K_W-1:0]     nd_quo [3];
  logic [2:0]         nd_nz;
  logic [2:0]         nd_qual, nd_big;

  for (genvar i = 0; i < 3; i++) begin : g_need
    twpfs_div #(
      .DEN_W (WW),
      .STEPS (K_W),
      .SIDE_W(2)
    ) u_div (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (en),
      .valid_i (b3_vld_q),
      .rem_i   (need_rem[i]),
      .den_i   (b3_mag_q[i]),
      .num_i   ('0),
      .side_i  ({qual[i], big[i]}),
      .valid_o (nd_vld[i]),
      .quo_o   (nd_quo[i]),
      .rem_nz_o(nd_nz[i]),
      .side_o  ({nd_qual[i], nd_big[i]})
    );
  end

  logic               cp_vld;
  logic [K_W-1:0]     cp_quo;
  logic               cp_nocap;
  logic [2:0]         cp_act, cp_neg;
  logic [2:0][WW-1:0] cp_mag;
  logic [SIDE_W-1:0]  cp_side;

  twpfs_div #(
    .DEN_W (WW),
    .STEPS (K_W),
    .SIDE_W(SIDE_W)
  ) u_cap_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (b3_vld_q),
    .rem_i   (cap_rem),
    .den_i   (b3_amax_q),
    .num_i   ('0),
    .side_i  ({nocap, b3_act_q, b3_neg_q, b3_mag_q}),
    .valid_o (cp_vld),
    .quo_o   (cp_quo),
    .rem_nz_o(),
    .side_o  (cp_side)
  );

  assign {cp_nocap, cp_act, cp_neg, cp_mag} = cp_side;

  // Gain: largest lift of the qualified wheels, then the cap
  logic [K_W-1:0] k_d;

  always_comb begin
    logic [K_W:0]   sum;
    logic [K_W-1:0] need;
    k_d = K_ONE;
    for (int i = 0; i < 3; i++) begin
      sum  = {1'b0, nd_quo[i]} + (K_W+1)'(nd_nz[i]);
      need = (nd_big[i] || sum[K_W]) ? K_MAX : sum[K_W-1:0];
      if (nd_qual[i] && need > k_d) k_d = need;
    end
    if (!cp_nocap && k_d > cp_quo) k_d = cp_quo;
  end

  // Stage 4: gain; stage 5: product
  logic               b4_vld_q, b5_vld_q;
  logic [K_W-1:0]     b4_k_q;
  logic [2:0]         b4_act_q, b4_neg_q, b5_act_q, b5_neg_q;
  logic [2:0][WW-1:0] b4_mag_q;
  logic [PROD_W-1:0]  b5_prod_q [3];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b4_vld_q  <= 1'b0;
      b5_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else if (en) begin
      b4_vld_q  <= cp_vld && (&nd_vld);
      b5_vld_q  <= b4_vld_q;
      out_vld_q <= b5_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      b4_k_q   <= k_d;
      b4_act_q <= cp_act;
      b4_neg_q <= cp_neg;
      b4_mag_q <= cp_mag;
      b5_act_q <= b4_act_q;
      b5_neg_q <= b4_neg_q;
      for (int i = 0; i < 3; i++) begin
        b5_prod_q[i] <= PROD_W'(b4_mag_q[i]) * PROD_W'(b4_k_q);
      end
    end
  end

  // Round, floor test, saturate, sign
  logic [2:0][DRIVE_BITS-1:0] drive_d, drive_q;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      logic [PROD_W-1:0]     v;
      logic [WW-1:0]         m;
      logic [DRIVE_BITS-2:0] m_sat;
      logic                  below;
      v     = b5_prod_q[i] + PROD_W'(K_MAX / 2 + 1);
      below = v < PROD_W'({cfg_i.floors[i], {K_W{1'b0}}});
      m     = v[PROD_W-1:K_W];
      m_sat = (|m[WW-1:DRIVE_BITS-1]) ? '1 : m[DRIVE_BITS-2:0];
      if (!b5_act_q[i] || below) begin
        drive_d[i] = '0;
      end else if (b5_neg_q[i]) begin
        drive_d[i] = ~{1'b0, m_sat} + 1'b1;
      end else begin
        drive_d[i] = {1'b0, m_sat};
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      drive_q <= drive_d;
    end
  end

  assign out_valid_o = out_vld_q;
  assign drive_o     = drive_q;

endmodule

`default_nettype wire

@@ src/three_wheel_pwm_floor_scaler.sv @@
// Each result passes the front and back divider pipelines, one quotient bit per stage.
// Throughput: one item per cycle while the output is not stalled; a four-entry queue
// decouples front and back.
// Reset: asynchronous, active low; efficiencies return to 100, all other
// configuration registers to 0, and every pipeline and the queue are emptied.
`default_nettype none

module three_wheel_pwm_floor_scaler import twpfs_pkg::*; #(
  parameter int unsigned DRIVE_BITS = 13
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  twpfs_raw_if.sink       raw_i,
  twpfs_cfg_if.sink       cfg_i,
  twpfs_drive_if.source   drive_o
);

  localparam int unsigned WW    = DRIVE_BITS + 7;
  localparam int unsigned ENT_W = 6 + 3 * WW;

  // Configuration registers
  cfg_t cfg_q;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.eff    <= {3{EFF_DEFAULT}};
      cfg_q.dead   <= '0;
      cfg_q.floors <= '0;
      cfg_q.cap    <= '0;
    end else if (cfg_i.valid) begin
      unique case (cfg_idx_e'(cfg_i.index))
        CFG_EFF0:   cfg_q.eff[0]    <= cfg_i.data[EFF_W-1:0];
        CFG_EFF1:   cfg_q.eff[1]    <= cfg_i.data[EFF_W-1:0];
        CFG_EFF2:   cfg_q.eff[2]    <= cfg_i.data[EFF_W-1:0];
        CFG_DEAD:   cfg_q.dead      <= cfg_i.data[LVL_W-1:0];
        CFG_FLOOR0: cfg_q.floors[0] <= cfg_i.data[LVL_W-1:0];
        CFG_FLOOR1: cfg_q.floors[1] <= cfg_i.data[LVL_W-1:0];
        CFG_FLOOR2: cfg_q.floors[2] <= cfg_i.data[LVL_W-1:0];
        CFG_CAP:    cfg_q.cap       <= cfg_i.data[LVL_W-1:0];
        default:    ;
      endcase
    end
  end

  // Front, queue, back
  logic                       push, pop, fifo_full, fifo_empty;
  logic [ENT_W-1:0]           ent_in, ent_out;
  logic [2:0][DRIVE_BITS-1:0] drive;

  twpfs_front #(.DRIVE_BITS(DRIVE_BITS)) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg_q),
    .in_valid_i (raw_i.valid),
    .in_ready_o (raw_i.ready),
    .raw_i      ({raw_i.wheel2_raw, raw_i.wheel1_raw, raw_i.wheel0_raw}),
    .fifo_full_i(fifo_full),
    .push_o     (push),
    .entry_o    (ent_in)
  );

  twpfs_fifo #(.W(ENT_W)) u_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .data_i (ent_in),
    .pop_i  (pop),
    .data_o (ent_out),
    .full_o (fifo_full),
    .empty_o(fifo_empty)
  );

  twpfs_back #(.DRIVE_BITS(DRIVE_BITS)) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .fifo_empty_i(fifo_empty),
    .entry_i     (ent_out),
    .pop_o       (pop),
    .out_valid_o (drive_o.valid),
    .out_ready_i (drive_o.ready),
    .drive_o     (drive)
  );

  assign drive_o.wheel0_drive = drive[0];
  assign drive_o.wheel1_drive = drive[1];
  assign drive_o.wheel2_drive = drive[2];

`ifndef ASSERT_OFF
  localparam logic [DRIVE_BITS-1:0] DRIVE_MIN = {1'b1, {(DRIVE_BITS-1){1'b0}}};

  assert property (@(posedge clk_i) disable iff (!rst_ni) push |-> !fifo_full)
    else $error("queue written while full");

  assert property (@(posedge clk_i) disable iff (!rst_ni) pop |-> !fifo_empty)
    else $error("queue read while empty");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    drive_o.valid |-> (drive_o.wheel0_drive != DRIVE_MIN) &&
                      (drive_o.wheel1_drive != DRIVE_MIN) &&
                      (drive_o.wheel2_drive != DRIVE_MIN))
    else $error("drive outside saturated range");
`endif

endmodule

`default_nettype wire

@@ test/three_wheel_pwm_floor_scaler_test.sv @@
`timescale 1ns / 100ps

module three_wheel_pwm_floor_scaler_test;
  import twpfs_pkg::*;

  localparam int unsigned DB = 13;
  localparam longint unsigned WSAT = (64'd1 << (DB + 7)) - 1;
  localparam longint unsigned OSAT = (64'd1 << (DB - 1)) - 1;
  localparam longint unsigned GAIN_ONE = 64'd65536;
  localparam longint unsigned GAIN_SAT = (64'd1 << 24) - 1;
  localparam int unsigned LATENCY = DB + 48;
  localparam longint unsigned CYCLE_LIMIT = 64'd2_000_000;

  typedef logic [DB-1:0] drive_t;
  typedef struct packed {
    drive_t w0;
    drive_t w1;
    drive_t w2;
  } triple_t;

  logic clk_i;
  logic rst_ni;

  twpfs_raw_if #(.DRIVE_BITS(DB)) raw_if ();
  twpfs_drive_if #(.DRIVE_BITS(DB)) drv_if ();
  twpfs_cfg_if cfg_if ();

  three_wheel_pwm_floor_scaler #(.DRIVE_BITS(DB)) dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .raw_i  (raw_if.sink),
    .cfg_i  (cfg_if.sink),
    .drive_o(drv_if.source)
  );

  // Register shadow and drive scaling prediction
  class drive_scoreboard;
    logic [EFF_W-1:0] eff[3];
    logic [LVL_W-1:0] dead;
    logic [LVL_W-1:0] floors[3];
    logic [LVL_W-1:0] cap;
    triple_t pending[$];
    int mismatches;

    function void reset_regs();
      for (int i = 0; i < 3; i++) begin
        eff[i] = EFF_DEFAULT;
        floors[i] = '0;
      end
      dead = '0;
      cap = '0;
    endfunction

    function void write_reg(cfg_idx_e idx, logic [CFG_DATA_W-1:0] val);
      case (idx)
        CFG_EFF0: eff[0] = val[EFF_W-1:0];
        CFG_EFF1: eff[1] = val[EFF_W-1:0];
        CFG_EFF2: eff[2] = val[EFF_W-1:0];
        CFG_DEAD: dead = val;
        CFG_FLOOR0: floors[0] = val;
        CFG_FLOOR1: floors[1] = val;
        CFG_FLOOR2: floors[2] = val;
        CFG_CAP: cap = val;
        default: ;
      endcase
    endfunction

    function triple_t scale(triple_t raw);
      drive_t r[3];
      drive_t o[3];
      longint unsigned mag[3];
      bit neg[3];
      bit act[3];
      longint unsigned amax;
      longint unsigned gain;
      longint unsigned e, a, need, v, m, fl;
      triple_t res;
      r[0] = raw.w0;
      r[1] = raw.w1;
      r[2] = raw.w2;
      amax = 0;
      gain = GAIN_ONE;
      for (int i = 0; i < 3; i++) begin
        e = (eff[i] == 0) ? 100 : eff[i];
        neg[i] = r[i][DB-1];
        a = neg[i] ? ((64'd1 << DB) - r[i]) : r[i];
        a = (a * 25600) / e;
        if (a > WSAT) a = WSAT;
        act[i] = a > (longint'(dead) << 8);
        mag[i] = act[i] ? a : 0;
        if (act[i] && mag[i] > amax) amax = mag[i];
      end
      // lift to the floors of the qualifying wheels
      for (int i = 0; i < 3; i++) begin
        if (act[i] && mag[i] * 100 >= amax * 35) begin
          need = ((longint'(floors[i]) << 24) + mag[i] - 1) / mag[i];
          if (need > GAIN_SAT) need = GAIN_SAT;
          if (need > gain) gain = need;
        end
      end
      if (cap != 0 && amax != 0 && amax * gain > (longint'(cap) << 24))
        gain = (longint'(cap) << 24) / amax;
      for (int i = 0; i < 3; i++) begin
        fl = longint'(floors[i]) << 24;
        v = mag[i] * gain + (64'd1 << 23);
        if (!act[i] || v < fl) begin
          o[i] = '0;
        end else begin
          m = v >> 24;
          if (m > OSAT) m = OSAT;
          o[i] = neg[i] ? drive_t'(-m) : drive_t'(m);
        end
      end
      res.w0 = o[0];
      res.w1 = o[1];
      res.w2 = o[2];
      return res;
    endfunction

    function void note_input(triple_t raw);
      pending.push_back(scale(raw));
    endfunction

    function void check_result(triple_t got);
      triple_t want;
      if (pending.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %h %h %h", got.w0, got.w1, got.w2);
        return;
      end
      want = pending.pop_front();
      if (got !== want) begin
        mismatches++;
        if (mismatches <= 10)
          $display("drive mismatch: expected %0d %0d %0d actual %0d %0d %0d",
                   $signed(want.w0), $signed(want.w1), $signed(want.w2),
                   $signed(got.w0), $signed(got.w1), $signed(got.w2));
      end
    endfunction
  endclass

  drive_scoreboard sb;
  int send_idle_pct;
  int recv_idle_pct;
  longint unsigned cycles;

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // watchdog
  initial begin
    cycles = 0;
    forever begin
      @(posedge clk_i);
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
        $display("three_wheel_pwm_floor_scaler_test: errors");
        $finish;
      end
    end
  end

  // receiver: random stall, check each result transfer
  initial begin
    drv_if.ready = 1'b0;
    forever begin
      @(posedge clk_i);
      if (rst_ni && drv_if.valid && drv_if.ready)
        sb.check_result({drv_if.wheel0_drive, drv_if.wheel1_drive, drv_if.wheel2_drive});
      drv_if.ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // valid stays high across back-to-back items; drain() drops it
  task automatic send_item(drive_t a, drive_t b, drive_t c);
    while ($urandom_range(99) < send_idle_pct) begin
      raw_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    raw_if.valid <= 1'b1;
    raw_if.wheel0_raw <= a;
    raw_if.wheel1_raw <= b;
    raw_if.wheel2_raw <= c;
    do @(posedge clk_i); while (!raw_if.ready);
    sb.note_input({a, b, c});
  endtask

  task automatic write_reg(cfg_idx_e idx, logic [CFG_DATA_W-1:0] val);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data <= val;
    do @(posedge clk_i); while (!cfg_if.ready);
    sb.write_reg(idx, val);
  endtask

  task automatic drain();
    raw_if.valid <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  function automatic drive_t rand_raw();
    int unsigned sel;
    sel = $urandom_range(9);
    case (sel)
      0: return drive_t'(13'h1000);
      1: return drive_t'($urandom_range(40));
      2: return drive_t'(-$signed($urandom_range(40)));
      default: return drive_t'($urandom);
    endcase
  endfunction

  task automatic write_all(logic [EFF_W-1:0] e0, e1, e2, logic [LVL_W-1:0] dz,
                           logic [LVL_W-1:0] f0, f1, f2, logic [LVL_W-1:0] cp);
    write_reg(CFG_EFF0, CFG_DATA_W'(e0));
    write_reg(CFG_EFF1, CFG_DATA_W'(e1));
    write_reg(CFG_EFF2, CFG_DATA_W'(e2));
    write_reg(CFG_DEAD, dz);
    write_reg(CFG_FLOOR0, f0);
    write_reg(CFG_FLOOR1, f1);
    write_reg(CFG_FLOOR2, f2);
    write_reg(CFG_CAP, cp);
    cfg_if.valid <= 1'b0;
  endtask

  // random register setting; extremes show up often
  function automatic logic [LVL_W-1:0] rand_lvl(int unsigned top);
    case ($urandom_range(5))
      0: return '0;
      1: return LVL_W'(top);
      2: return LVL_W'($urandom_range(200));
      default: return LVL_W'($urandom_range(top));
    endcase
  endfunction

  task automatic random_batch(int n);
    for (int i = 0; i < n; i++) send_item(rand_raw(), rand_raw(), rand_raw());
  endtask

  initial begin
    sb = new();
    sb.reset_regs();
    sb.mismatches = 0;
    send_idle_pct = 0;
    recv_idle_pct = 0;
    raw_if.valid = 1'b0;
    raw_if.wheel0_raw = '0;
    raw_if.wheel1_raw = '0;
    raw_if.wheel2_raw = '0;
    cfg_if.valid = 1'b0;
    cfg_if.index = CFG_EFF0;
    cfg_if.data = '0;
    rst_ni = 1'b0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: reset settings, extremes and the most negative input
    send_item(13'd0, 13'd0, 13'd0);
    send_item(13'd4095, -13'sd4095, 13'h1000);
    send_item(13'd1, -13'sd1, 13'd100);
    drain();
    // small efficiency saturates, huge gain, floors, dead band, cap disabled
    write_all(10'd1, 10'd0, 10'd1023, 12'd5, 12'd4095, 12'd0, 12'd300, 12'd0);
    send_item(13'd4095, 13'd3, 13'd7);
    send_item(13'h1000, -13'sd6, 13'd2000);
    send_item(13'd1, 13'd1, 13'd1);
    send_item(13'd500, 13'd200, -13'sd900);
    drain();
    write_all(10'd100, 10'd50, 10'd200, 12'd0, 12'd100, 12'd4095, 12'd1, 12'd4095);
    send_item(13'd10, 13'd10, 13'd10);
    send_item(-13'sd1, 13'd2, -13'sd3);
    send_item(13'd4095, 13'd4095, 13'd4095);
    drain();
    write_all(10'd100, 10'd100, 10'd100, 12'd4095, 12'd0, 12'd0, 12'd0, 12'd1);
    send_item(13'd4095, 13'h1000, 13'd4094);
    send_item(13'd3000, -13'sd2000, 13'd100);
    drain();
    write_all(10'd100, 10'd100, 10'd100, 12'd0, 12'd50, 12'd60, 12'd70, 12'd2000);
    send_item(13'd100, 13'd34, 13'd36);
    send_item(-13'sd4000, 13'd1400, 13'd1399);
    send_item(13'd20, -13'sd20, 13'd1);

    // random phases with idling mixes, registers rewritten between phases
    for (int ph = 0; ph < 12; ph++) begin
      drain();
      write_all($urandom_range(3) == 0 ? 10'd0 : 10'($urandom_range(1023)),
                10'($urandom_range(150)), $urandom_range(4) == 0 ? 10'd1023 : 10'd100,
                rand_lvl(60), rand_lvl(4095), rand_lvl(4095), rand_lvl(4095),
                rand_lvl(4095));
      if (ph < 4) begin
        send_idle_pct = 8;
        recv_idle_pct = 74;
      end else if (ph < 8) begin
        send_idle_pct = 74;
        recv_idle_pct = 8;
      end else begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      random_batch(140);
    end

    // end of stimulus
    drain();
    repeat (LATENCY + 10) @(posedge clk_i);
    if (sb.mismatches == 0 && sb.pending.size() == 0) begin
      $display("three_wheel_pwm_floor_scaler_test: clean");
    end else begin
      $display("three_wheel_pwm_floor_scaler_test: errors");
    end
    $finish;
  end

endmodule
